FILE: hdl/rfdc_pkg.sv
// Shared types and constants for the access-tag frame decoder and checker.
package rfdc_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CARD_W  = 24;
	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned YBIN_W  = 8;
	localparam int unsigned PIVOT_W = 7;
	localparam int unsigned INDEX_W = 2;

	localparam logic [WORD_W-1:0]  HEADER_RESET = 32'hBB0214FF;
	localparam logic [PIVOT_W-1:0] PIVOT_RESET  = 7'd60;
	localparam logic [YEAR_W-1:0]  CENTURY_OLD  = 12'd1900;
	localparam logic [YEAR_W-1:0]  CENTURY_NEW  = 12'd2000;

	typedef enum logic [INDEX_W-1:0] {
		REG_HEADER = 2'd0,
		REG_PIVOT  = 2'd1
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_VALID = 2'd0,
		STATUS_CHK1  = 2'd1,
		STATUS_CHK2  = 2'd2
	} status_t;

	typedef struct packed {
		logic [CARD_W-1:0] card_hi;
		logic [CARD_W-1:0] card_lo;
		logic [YBIN_W-1:0] year_bin;
		logic              chk1_ok;
		logic              chk2_ok;
		logic              hdr_bad;
	} partial_t;

endpackage

FILE: hdl/rfid_frame_decode_check_top.sv
// Top level of the access-tag frame decoder and checker with its register file.
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+---------------------------------------------
//  frame    | start, busy (transfer on start && !busy) | word_first, word_middle, word_last
//  result   | done (one-cycle strobe)       | card_number, issue_year, status, header_unexpected
//  config   | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// A frame is registered on entry and passes through the extract and finish stages before its result appears on done.
// One frame can be taken in every cycle, so busy is always low.
// Reset clears the valid bits and loads the header and pivot registers with their defaults.
// The receiver cannot stall, so every stage advances on every clock.
module rfid_frame_decode_check_top
	import rfdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [WORD_W-1:0]  word_first,
	input  logic [WORD_W-1:0]  word_middle,
	input  logic [WORD_W-1:0]  word_last,
	output logic               done,
	output logic [CARD_W-1:0]  card_number,
	output logic [YEAR_W-1:0]  issue_year,
	output logic [1:0]         status,
	output logic               header_unexpected,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]  cfg_data
);

	logic [WORD_W-1:0]  header_q;
	logic [PIVOT_W-1:0] pivot_q;
	logic               valid_s1;
	logic [WORD_W-1:0]  first_s1;
	logic [WORD_W-1:0]  middle_s1;
	logic [WORD_W-1:0]  last_s1;
	logic               valid_s2;
	partial_t           part_s2;
	status_t            status_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			pivot_q  <= PIVOT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEADER: header_q <= cfg_data;
				REG_PIVOT:  pivot_q  <= cfg_data[PIVOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			first_s1  <= word_first;
			middle_s1 <= word_middle;
			last_s1   <= word_last;
		end
	end

	rfdc_extract u_extract (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_in        (valid_s1),
		.word_first      (first_s1),
		.word_middle     (middle_s1),
		.word_last       (last_s1),
		.expected_header (header_q),
		.valid_s2        (valid_s2),
		.part_s2         (part_s2)
	);

	rfdc_finish u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_in      (valid_s2),
		.part_in       (part_s2),
		.century_pivot (pivot_q),
		.valid_s3      (done),
		.card_s3       (card_number),
		.year_s3       (issue_year),
		.status_s3     (status_s3),
		.hdr_bad_s3    (header_unexpected)
	);

	assign status = status_s3;

endmodule

FILE: hdl/rfdc_extract.sv
// Second pipeline stage: digit weighting, checksum folding and header compare.
module rfdc_extract
	import rfdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  logic [WORD_W-1:0] word_first,
	input  logic [WORD_W-1:0] word_middle,
	input  logic [WORD_W-1:0] word_last,
	input  logic [WORD_W-1:0] expected_header,
	output logic              valid_s2,
	output partial_t          part_s2
);

	partial_t   part_d;
	logic [3:0] sum1;
	logic [3:0] sum2;
	logic [3:0] mid_x;
	logic [3:0] first_x;

	always_comb begin
		mid_x   = 4'd0;
		first_x = 4'd0;
		for (int i = 0; i < 8; i++) begin
			mid_x   = mid_x ^ word_middle[4*i +: 4];
			first_x = first_x ^ word_first[4*i +: 4];
		end
		sum1 = mid_x ^ word_last[31:28] ^ word_last[27:24];
		sum2 = first_x ^ mid_x ^ word_last[31:28] ^ word_last[27:24] ^ word_last[23:20];

		part_d.card_hi = CARD_W'(word_middle[31:28]) * CARD_W'(1000000)
			+ CARD_W'(word_middle[27:24]) * CARD_W'(100000)
			+ CARD_W'(word_middle[23:20]) * CARD_W'(10000);
		part_d.card_lo = CARD_W'(word_middle[7:4]) * CARD_W'(1000)
			+ CARD_W'(word_middle[3:0]) * CARD_W'(100)
			+ CARD_W'(word_last[31:28]) * CARD_W'(10)
			+ CARD_W'(word_last[27:24]);
		part_d.year_bin = YBIN_W'(word_middle[19:16]) * YBIN_W'(10)
			+ YBIN_W'(word_middle[15:12]);
		part_d.chk1_ok = (sum1 == word_last[23:20]);
		part_d.chk2_ok = (sum2 == word_last[19:16]);
		part_d.hdr_bad = (word_first != expected_header);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			part_s2 <= part_d;
		end
	end

endmodule

FILE: hdl/rfdc_finish.sv
// Third pipeline stage: card number sum, century window and status encoding.
module rfdc_finish
	import rfdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  partial_t           part_in,
	input  logic [PIVOT_W-1:0] century_pivot,
	output logic               valid_s3,
	output logic [CARD_W-1:0]  card_s3,
	output logic [YEAR_W-1:0]  year_s3,
	output status_t            status_s3,
	output logic               hdr_bad_s3
);

	logic [CARD_W-1:0] card_d;
	logic [YEAR_W-1:0] year_d;
	status_t           status_d;

	always_comb begin
		card_d = part_in.card_hi + part_in.card_lo;
		if (part_in.year_bin > {1'b0, century_pivot}) begin
			year_d = YEAR_W'(part_in.year_bin) + CENTURY_OLD;
		end else begin
			year_d = YEAR_W'(part_in.year_bin) + CENTURY_NEW;
		end
		if (!part_in.chk1_ok) begin
			status_d = STATUS_CHK1;
		end else if (!part_in.chk2_ok) begin
			status_d = STATUS_CHK2;
		end else begin
			status_d = STATUS_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			card_s3    <= card_d;
			year_s3    <= year_d;
			status_s3  <= status_d;
			hdr_bad_s3 <= part_in.hdr_bad;
		end
	end

endmodule
